>>> rtl/bahp_pkg.sv
// Shared widths, limits, register codes and helpers for the altitude hold block.
`timescale 1ns / 1ps

package bahp_pkg;

  // Field widths
  localparam int ALT_W      = 21;
  localparam int ALT_MAG_W  = ALT_W - 1;
  localparam int SAMPLE_W   = 18;
  localparam int DRIVE_W    = 9;
  localparam int GAIN_W     = 8;
  localparam int INTEG_W    = 16;
  localparam int EI_Q_W     = 24;
  localparam int PTERM_W    = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ALT_W;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ALTITUDE = 2'd3;

  localparam logic [GAIN_W-1:0] P_GAIN_RST = 8'd16;
  localparam logic [GAIN_W-1:0] I_GAIN_RST = 8'd15;
  localparam logic [GAIN_W-1:0] D_GAIN_RST = 8'd7;

  // History window
  localparam int HISTORY_DEPTH_DEF = 40;

  // Limits and fixed divisors
  localparam int ALT_LIMIT   = 1000000;
  localparam int PD_LIMIT    = 150;
  localparam int INTEG_LIMIT = 30000;
  localparam int DEADBAND    = 10;
  localparam int SAMPLE_DIV  = 10;
  localparam int P_DIV       = 100;
  localparam int I_DIV       = 50;
  localparam int SHARE_DIV   = 500;

  localparam logic signed [ALT_W-1:0] ALT_POS = ALT_W'(ALT_LIMIT);
  localparam logic signed [ALT_W-1:0] ALT_NEG = ALT_W'(-ALT_LIMIT);

  // Width of a half-window sum; the newest half is the larger one
  function automatic int sum_w(input int depth);
    return SAMPLE_W + $clog2(depth - depth / 2);
  endfunction

endpackage

>>> rtl/bahp_cell.sv
// One history cell: holds a sample and passes it to the next cell on a shift.
`timescale 1ns / 1ps

module bahp_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift,
  input  logic signed [bahp_pkg::SAMPLE_W-1:0] d_in,
  output logic signed [bahp_pkg::SAMPLE_W-1:0] q
);

  logic signed [bahp_pkg::SAMPLE_W-1:0] q_r;

  // Load the neighbor's sample on a shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/bahp_cdiv.sv
// Unsigned divide by a fixed divisor through a reciprocal multiply.
`timescale 1ns / 1ps

module bahp_cdiv #(
  parameter int MAG_W   = bahp_pkg::ALT_MAG_W,
  parameter int DIVISOR = bahp_pkg::SAMPLE_DIV
) (
  input  logic [MAG_W-1:0] mag,
  output logic [MAG_W-1:0] quo
);

  // Reciprocal with enough fraction bits to be exact over the full input range
  localparam int SH = $clog2(DIVISOR);
  localparam int K  = MAG_W + SH;
  localparam int KW = K + 1;
  localparam logic [KW-1:0] POW_K      = {1'b1, {K{1'b0}}};
  localparam logic [KW-1:0] RECIP_FULL = (POW_K + KW'(DIVISOR - 1)) / KW'(DIVISOR);
  localparam logic [MAG_W:0] RECIP     = RECIP_FULL[MAG_W:0];

  logic [2*MAG_W:0] prod;

  // Multiply and drop the fraction
  assign prod = {{(MAG_W + 1){1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP};
  assign quo  = MAG_W'(prod[2*MAG_W:K]);

endmodule

>>> rtl/bahp_window.sv
// Shift line of history cells with running sums over its newest and oldest halves.
`timescale 1ns / 1ps

module bahp_window #(
  parameter int DEPTH = bahp_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        shift,
  input  logic signed [bahp_pkg::SAMPLE_W-1:0]        sample,
  output logic signed [bahp_pkg::sum_w(DEPTH)-1:0]    newest_sum,
  output logic signed [bahp_pkg::sum_w(DEPTH)-1:0]    oldest_sum
);

  localparam int SUM_W   = bahp_pkg::sum_w(DEPTH);
  localparam int NEW_CNT = DEPTH - DEPTH / 2;

  logic signed [bahp_pkg::SAMPLE_W-1:0] cell_q [DEPTH];
  logic signed [SUM_W-1:0] newest_r, newest_nxt;
  logic signed [SUM_W-1:0] oldest_r, oldest_nxt;

  // Chain the cells: the newest sample enters at the head
  bahp_cell u_cell_head (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (shift),
    .d_in  (sample),
    .q     (cell_q[0])
  );

  for (genvar g = 1; g < DEPTH; g++) begin : g_cell
    bahp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d_in  (cell_q[g-1]),
      .q     (cell_q[g])
    );
  end

  // Move the sample crossing the half boundary and drop the evicted one
  assign newest_nxt = newest_r + SUM_W'(sample) - SUM_W'(cell_q[NEW_CNT-1]);
  assign oldest_nxt = oldest_r + SUM_W'(cell_q[NEW_CNT-1]) - SUM_W'(cell_q[DEPTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      oldest_r <= '0;
    end else if (shift) begin
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  assign newest_sum = newest_r;
  assign oldest_sum = oldest_r;

endmodule

>>> rtl/baro_altitude_hold_pid_top.sv
// Top level: barometric altitude estimator and PID drive, twelve-stage pipeline.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid/in_ready    in_raw_altitude
//   out_     result     out_valid/out_ready  out_estimated_altitude, out_drive_output
//   cfg_     write      cfg_we               cfg_index, cfg_data
//
// Takes one request per cycle while out_ready is high or a stage is empty; each
// result passes through the twelve register stages of the datapath (four reciprocal
// multiplies in series).
// Reset clears stage valid flags, history cells, half sums, integrator and registers;
// the history is a row of flip-flops, so no clearing pass follows reset.
// An output stall first fills empty stages; in_ready drops only when every stage is full.
`timescale 1ns / 1ps

module baro_altitude_hold_pid_top #(
  parameter int HISTORY_DEPTH = bahp_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [bahp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bahp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bahp_pkg::ALT_W-1:0]      in_raw_altitude,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bahp_pkg::ALT_W-1:0]      out_estimated_altitude,
  output logic signed [bahp_pkg::DRIVE_W-1:0]    out_drive_output
);

  localparam int NSTG        = 12;
  localparam int ALT_W       = bahp_pkg::ALT_W;
  localparam int ALT_MAG_W   = bahp_pkg::ALT_MAG_W;
  localparam int SAMPLE_W    = bahp_pkg::SAMPLE_W;
  localparam int GAIN_W      = bahp_pkg::GAIN_W;
  localparam int DRIVE_W     = bahp_pkg::DRIVE_W;
  localparam int INTEG_W     = bahp_pkg::INTEG_W;
  localparam int EI_Q_W      = bahp_pkg::EI_Q_W;
  localparam int PTERM_W     = bahp_pkg::PTERM_W;
  localparam int SUM_W       = bahp_pkg::sum_w(HISTORY_DEPTH);
  localparam int EST_W       = SUM_W + 4;
  localparam int EST_MAG_W   = SUM_W + 3;
  localparam int AVG_MAG_W   = SUM_W - 1;
  localparam int DIFF_W      = SUM_W + 1;
  localparam int PD_W        = DIFF_W + GAIN_W + 1;
  localparam int PDS_W       = PD_W + 1;
  localparam int ERR_W       = ALT_W + 1;
  localparam int ERR_MAG_W   = ALT_W;
  localparam int PC_W        = GAIN_W + 1;
  localparam int EI_MAG_W    = ERR_MAG_W + GAIN_W;
  localparam int PPROD_W     = PC_W + GAIN_W;
  localparam int INTEG_SUM_W = EI_Q_W + 2;
  localparam int IMAG_W      = INTEG_W - 1;

  localparam logic [EST_MAG_W-1:0]     EST_MAX = EST_MAG_W'(bahp_pkg::ALT_LIMIT);
  localparam logic signed [ERR_W-1:0]  ERR_DB  = ERR_W'(bahp_pkg::DEADBAND);
  localparam logic signed [PD_W-1:0]   PD_DB   = PD_W'(bahp_pkg::DEADBAND);
  localparam logic signed [PDS_W-1:0]  PD_MAX  = PDS_W'(bahp_pkg::PD_LIMIT);
  localparam logic signed [PDS_W-1:0]  PD_MIN  = PDS_W'(-bahp_pkg::PD_LIMIT);
  localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX = INTEG_SUM_W'(bahp_pkg::INTEG_LIMIT);
  localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN = INTEG_SUM_W'(-bahp_pkg::INTEG_LIMIT);

  // Configuration registers
  logic [GAIN_W-1:0]       p_gain_r, i_gain_r, d_gain_r;
  logic signed [ALT_W-1:0] hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r <= bahp_pkg::P_GAIN_RST;
      i_gain_r <= bahp_pkg::I_GAIN_RST;
      d_gain_r <= bahp_pkg::D_GAIN_RST;
      hold_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bahp_pkg::REG_P_GAIN:        p_gain_r <= cfg_data[GAIN_W-1:0];
        bahp_pkg::REG_I_GAIN:        i_gain_r <= cfg_data[GAIN_W-1:0];
        bahp_pkg::REG_D_GAIN:        d_gain_r <= cfg_data[GAIN_W-1:0];
        bahp_pkg::REG_HOLD_ALTITUDE: hold_r   <= signed'(cfg_data[ALT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage flow control: a stage loads when it or any later stage has room
  logic [NSTG:1] valid_r;
  logic [NSTG:1] stage_rdy;
  logic [NSTG:1] valid_nxt;

  assign valid_nxt = {valid_r[NSTG-1:1], in_valid};

  for (genvar g = 1; g <= NSTG; g++) begin : g_vld
    assign stage_rdy[g] = out_ready || !(&valid_r[NSTG:g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (stage_rdy[g]) begin
        valid_r[g] <= valid_nxt[g];
      end
    end
  end

  assign in_ready  = stage_rdy[1];
  assign out_valid = valid_r[NSTG];

  // Stage 1: saturate the sample and split off its sign
  logic signed [ALT_W-1:0] raw_sat, raw_sat_neg;
  logic [ALT_MAG_W-1:0]    mag1_r;
  logic                    neg1_r;

  always_comb begin
    if (in_raw_altitude > bahp_pkg::ALT_POS) begin
      raw_sat = bahp_pkg::ALT_POS;
    end else if (in_raw_altitude < bahp_pkg::ALT_NEG) begin
      raw_sat = bahp_pkg::ALT_NEG;
    end else begin
      raw_sat = in_raw_altitude;
    end
  end

  assign raw_sat_neg = -raw_sat;

  always_ff @(posedge clk) begin
    if (stage_rdy[1]) begin
      mag1_r <= raw_sat[ALT_W-1] ? raw_sat_neg[ALT_MAG_W-1:0] : raw_sat[ALT_MAG_W-1:0];
      neg1_r <= raw_sat[ALT_W-1];
    end
  end

  // Stage 2: divide by ten toward zero
  logic [ALT_MAG_W-1:0]       q10;
  logic signed [SAMPLE_W-1:0] samp_abs, sample_r;

  bahp_cdiv #(.MAG_W(ALT_MAG_W), .DIVISOR(bahp_pkg::SAMPLE_DIV)) u_div_sample (
    .mag (mag1_r),
    .quo (q10)
  );

  assign samp_abs = SAMPLE_W'(q10);

  always_ff @(posedge clk) begin
    if (stage_rdy[2]) begin
      sample_r <= neg1_r ? -samp_abs : samp_abs;
    end
  end

  // Stage 3: shift the history and update the half sums
  logic signed [SUM_W-1:0] newest_sum, oldest_sum;

  bahp_window #(.DEPTH(HISTORY_DEPTH)) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift      (stage_rdy[3] && valid_r[2]),
    .sample     (sample_r),
    .newest_sum (newest_sum),
    .oldest_sum (oldest_sum)
  );

  // Stage 4: scale the newest sum by ten and take magnitudes
  logic signed [EST_W-1:0] new_ext, new_x10, new_x10_neg;
  logic signed [SUM_W-1:0] new_neg_val, old_neg_val;
  logic [EST_MAG_W-1:0]    est_num4_r;
  logic [AVG_MAG_W-1:0]    new_mag4_r, old_mag4_r;
  logic                    new_neg4_r, old_neg4_r;

  assign new_ext     = EST_W'(newest_sum);
  assign new_x10     = (new_ext <<< 3) + (new_ext <<< 1);
  assign new_x10_neg = -new_x10;
  assign new_neg_val = -newest_sum;
  assign old_neg_val = -oldest_sum;

  always_ff @(posedge clk) begin
    if (stage_rdy[4]) begin
      est_num4_r <= newest_sum[SUM_W-1] ? new_x10_neg[EST_MAG_W-1:0] : new_x10[EST_MAG_W-1:0];
      new_mag4_r <= newest_sum[SUM_W-1] ? new_neg_val[AVG_MAG_W-1:0] : newest_sum[AVG_MAG_W-1:0];
      old_mag4_r <= oldest_sum[SUM_W-1] ? old_neg_val[AVG_MAG_W-1:0] : oldest_sum[AVG_MAG_W-1:0];
      new_neg4_r <= newest_sum[SUM_W-1];
      old_neg4_r <= oldest_sum[SUM_W-1];
    end
  end

  // Stage 5: estimate over the half window and both averages over the full depth
  logic [EST_MAG_W-1:0] est_q;
  logic [AVG_MAG_W-1:0] new_q, old_q;
  logic [EST_MAG_W-1:0] est_q5_r;
  logic [AVG_MAG_W-1:0] new_q5_r, old_q5_r;
  logic                 new_neg5_r, old_neg5_r;

  bahp_cdiv #(.MAG_W(EST_MAG_W), .DIVISOR(HISTORY_DEPTH / 2)) u_div_est (
    .mag (est_num4_r),
    .quo (est_q)
  );

  bahp_cdiv #(.MAG_W(AVG_MAG_W), .DIVISOR(HISTORY_DEPTH)) u_div_new (
    .mag (new_mag4_r),
    .quo (new_q)
  );

  bahp_cdiv #(.MAG_W(AVG_MAG_W), .DIVISOR(HISTORY_DEPTH)) u_div_old (
    .mag (old_mag4_r),
    .quo (old_q)
  );

  always_ff @(posedge clk) begin
    if (stage_rdy[5]) begin
      est_q5_r   <= est_q;
      new_q5_r   <= new_q;
      old_q5_r   <= old_q;
      new_neg5_r <= new_neg4_r;
      old_neg5_r <= old_neg4_r;
    end
  end

  // Stage 6: limit the estimate, form oldest minus newest average
  logic [ALT_MAG_W-1:0]     est_mag;
  logic signed [ALT_W-1:0]  est_abs;
  logic signed [DIFF_W-1:0] new_avg_abs, old_avg_abs, new_avg, old_avg;
  logic signed [ALT_W-1:0]  est6_r;
  logic signed [DIFF_W-1:0] dneg6_r;

  assign est_mag     = (est_q5_r > EST_MAX) ? ALT_MAG_W'(bahp_pkg::ALT_LIMIT)
                                            : est_q5_r[ALT_MAG_W-1:0];
  assign est_abs     = signed'({1'b0, est_mag});
  assign new_avg_abs = signed'({2'b00, new_q5_r});
  assign old_avg_abs = signed'({2'b00, old_q5_r});
  assign new_avg     = new_neg5_r ? -new_avg_abs : new_avg_abs;
  assign old_avg     = old_neg5_r ? -old_avg_abs : old_avg_abs;

  always_ff @(posedge clk) begin
    if (stage_rdy[6]) begin
      est6_r  <= new_neg5_r ? -est_abs : est_abs;
      dneg6_r <= old_avg - new_avg;
    end
  end

  // Stage 7: derivative product and altitude error
  logic signed [PD_W-1:0]  d_gain_s;
  logic signed [PD_W-1:0]  pidd7_r;
  logic signed [ERR_W-1:0] err7_r;
  logic signed [ALT_W-1:0] est7_r;

  assign d_gain_s = PD_W'(signed'({1'b0, d_gain_r}));

  always_ff @(posedge clk) begin
    if (stage_rdy[7]) begin
      pidd7_r <= d_gain_s * PD_W'(dneg6_r);
      err7_r  <= ERR_W'(hold_r) - ERR_W'(est6_r);
      est7_r  <= est6_r;
    end
  end

  // Stage 8: dead band, clamp the proportional error, integral product
  logic                     dead_band;
  logic signed [ERR_W-1:0]  err_neg_val;
  logic [ERR_MAG_W-1:0]     err_mag;
  logic [PC_W-1:0]          p_max;
  logic signed [PD_W-1:0]   pidz8_r;
  logic [PC_W-1:0]          pcmag8_r;
  logic [EI_MAG_W-1:0]      eiprod8_r;
  logic                     errneg8_r;
  logic signed [ALT_W-1:0]  est8_r;

  assign dead_band   = (err7_r < ERR_DB) && (err7_r > -ERR_DB) &&
                       (pidd7_r < PD_DB) && (pidd7_r > -PD_DB);
  assign err_neg_val = -err7_r;
  assign err_mag     = err7_r[ERR_W-1] ? err_neg_val[ERR_MAG_W-1:0] : err7_r[ERR_MAG_W-1:0];
  assign p_max       = {p_gain_r, 1'b0};

  always_ff @(posedge clk) begin
    if (stage_rdy[8]) begin
      pidz8_r   <= dead_band ? '0 : pidd7_r;
      pcmag8_r  <= (err_mag > ERR_MAG_W'(p_max)) ? p_max : err_mag[PC_W-1:0];
      eiprod8_r <= EI_MAG_W'(err_mag) * EI_MAG_W'(i_gain_r);
      errneg8_r <= err7_r[ERR_W-1];
      est8_r    <= est7_r;
    end
  end

  // Stage 9: proportional product and integral step over fifty
  logic [EI_MAG_W-1:0]     ei_q;
  logic [PPROD_W-1:0]      pprod9_r;
  logic [EI_Q_W-1:0]       eiq9_r;
  logic                    errneg9_r;
  logic signed [PD_W-1:0]  pidz9_r;
  logic signed [ALT_W-1:0] est9_r;

  bahp_cdiv #(.MAG_W(EI_MAG_W), .DIVISOR(bahp_pkg::I_DIV)) u_div_integ (
    .mag (eiprod8_r),
    .quo (ei_q)
  );

  always_ff @(posedge clk) begin
    if (stage_rdy[9]) begin
      pprod9_r  <= PPROD_W'(pcmag8_r) * PPROD_W'(p_gain_r);
      eiq9_r    <= ei_q[EI_Q_W-1:0];
      errneg9_r <= errneg8_r;
      pidz9_r   <= pidz8_r;
      est9_r    <= est8_r;
    end
  end

  // Stage 10: proportional term over one hundred; accumulate and clamp the integrator
  logic [PPROD_W-1:0]             pterm_q;
  logic signed [PTERM_W-1:0]      pterm_abs;
  logic signed [INTEG_SUM_W-1:0]  ei_abs, ei_step, integ_sum, integ_clamped;
  logic signed [INTEG_W-1:0]      integ_r, integ_nxt;
  logic signed [PTERM_W-1:0]      pterm10_r;
  logic signed [PD_W-1:0]         pidz10_r;
  logic signed [ALT_W-1:0]        est10_r;

  bahp_cdiv #(.MAG_W(PPROD_W), .DIVISOR(bahp_pkg::P_DIV)) u_div_prop (
    .mag (pprod9_r),
    .quo (pterm_q)
  );

  assign pterm_abs = PTERM_W'(pterm_q);
  assign ei_abs    = INTEG_SUM_W'(eiq9_r);
  assign ei_step   = errneg9_r ? -ei_abs : ei_abs;
  assign integ_sum = INTEG_SUM_W'(integ_r) + ei_step;

  always_comb begin
    if (integ_sum > INTEG_MAX) begin
      integ_clamped = INTEG_MAX;
    end else if (integ_sum < INTEG_MIN) begin
      integ_clamped = INTEG_MIN;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  assign integ_nxt = INTEG_W'(integ_clamped);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (stage_rdy[10] && valid_r[9]) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[10]) begin
      pterm10_r <= errneg9_r ? -pterm_abs : pterm_abs;
      pidz10_r  <= pidz9_r;
      est10_r   <= est9_r;
    end
  end

  // Stage 11: limit P plus D, take the integrator magnitude
  logic signed [PDS_W-1:0]   pd_sum, pd_clamped;
  logic signed [INTEG_W-1:0] integ_neg_val;
  logic signed [DRIVE_W-1:0] pd11_r;
  logic [IMAG_W-1:0]         imag11_r;
  logic                      ineg11_r;
  logic signed [ALT_W-1:0]   est11_r;

  assign pd_sum        = PDS_W'(pidz10_r) + PDS_W'(pterm10_r);
  assign integ_neg_val = -integ_r;

  always_comb begin
    if (pd_sum > PD_MAX) begin
      pd_clamped = PD_MAX;
    end else if (pd_sum < PD_MIN) begin
      pd_clamped = PD_MIN;
    end else begin
      pd_clamped = pd_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[11]) begin
      pd11_r   <= DRIVE_W'(pd_clamped);
      imag11_r <= integ_r[INTEG_W-1] ? integ_neg_val[IMAG_W-1:0] : integ_r[IMAG_W-1:0];
      ineg11_r <= integ_r[INTEG_W-1];
      est11_r  <= est10_r;
    end
  end

  // Stage 12: add the integrator share and hold the result
  logic [IMAG_W-1:0]         share_q;
  logic signed [DRIVE_W-1:0] share_abs, share;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [ALT_W-1:0]   est_out_r;

  bahp_cdiv #(.MAG_W(IMAG_W), .DIVISOR(bahp_pkg::SHARE_DIV)) u_div_share (
    .mag (imag11_r),
    .quo (share_q)
  );

  assign share_abs = DRIVE_W'(share_q);
  assign share     = ineg11_r ? -share_abs : share_abs;

  always_ff @(posedge clk) begin
    if (stage_rdy[12]) begin
      drive_r   <= pd11_r + share;
      est_out_r <= est11_r;
    end
  end

  assign out_estimated_altitude = est_out_r;
  assign out_drive_output       = drive_r;

endmodule

>>> tb/bahp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the altitude hold block: predicts each result and compares it.
module bahp_result_checker
  import bahp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [ALT_W-1:0]     in_raw_altitude,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [ALT_W-1:0]     out_estimated_altitude,
  input  logic signed [DRIVE_W-1:0]   out_drive_output,
  output int                          mismatch_count,
  output int                          results_outstanding
);

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int HALF  = DEPTH / 2;

  typedef struct {
    logic signed [ALT_W-1:0]   altitude;
    logic signed [DRIVE_W-1:0] drive;
  } altitude_result_t;

  altitude_result_t expected_results[$];

  // Predictor state and register copies
  logic signed [SAMPLE_W-1:0] sample_window [DEPTH];
  int unsigned                slot_index;
  longint                     recent_sum;
  longint                     older_sum;
  logic signed [INTEG_W-1:0]  integrator;
  logic [GAIN_W-1:0]          kp;
  logic [GAIN_W-1:0]          ki;
  logic [GAIN_W-1:0]          kd;
  logic signed [ALT_W-1:0]    target_altitude;

  function automatic longint limit(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_state();
    for (int k = 0; k < DEPTH; k++) sample_window[k] = '0;
    slot_index = 0;
    recent_sum = 0;
    older_sum = 0;
    integrator = '0;
    kp = P_GAIN_RST;
    ki = I_GAIN_RST;
    kd = D_GAIN_RST;
    target_altitude = '0;
  endtask

  // Advance the window by one sample and work out estimate and drive
  task automatic predict_altitude_hold(input logic signed [ALT_W-1:0] raw,
                                       output altitude_result_t r);
    longint sample, evicted, moved, est, diff, pid, err, pterm, pmax, integ;
    longint p, i, d, hold;
    int unsigned mid;
    p = kp;
    i = ki;
    d = kd;
    hold = target_altitude;
    sample = limit(raw, -ALT_LIMIT, ALT_LIMIT) / SAMPLE_DIV;

    // Replace the oldest sample and shift one sample across the halves
    evicted = sample_window[slot_index];
    sample_window[slot_index] = SAMPLE_W'(sample);
    recent_sum += sample;
    mid = (slot_index + HALF) % DEPTH;
    moved = sample_window[mid];
    recent_sum -= moved;
    older_sum += moved - evicted;
    slot_index = (slot_index + 1 >= DEPTH) ? 0 : slot_index + 1;

    est = limit(recent_sum * SAMPLE_DIV / HALF, -ALT_LIMIT, ALT_LIMIT);

    // D term, zeroed inside the dead band
    diff = recent_sum / DEPTH - older_sum / DEPTH;
    pid = -(d * diff);
    err = hold - est;
    if (magnitude(err) < DEADBAND && magnitude(pid) < DEADBAND) pid = 0;

    // P term on a clamped error, then limit P plus D
    pmax = 2 * p;
    pterm = p * limit(err, -pmax, pmax) / P_DIV;
    pid = limit(pid + pterm, -PD_LIMIT, PD_LIMIT);

    // Integrate first, then clamp
    integ = integrator;
    integ = limit(integ + err * i / I_DIV, -INTEG_LIMIT, INTEG_LIMIT);
    integrator = INTEG_W'(integ);
    pid += integ / SHARE_DIV;

    r.altitude = ALT_W'(est);
    r.drive = DRIVE_W'(pid);
  endtask

  initial begin
    mismatch_count = 0;
    results_outstanding = 0;
  end

  always @(posedge clk) begin
    altitude_result_t oldest;
    altitude_result_t predicted;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_P_GAIN:        kp = cfg_data[GAIN_W-1:0];
          REG_I_GAIN:        ki = cfg_data[GAIN_W-1:0];
          REG_D_GAIN:        kd = cfg_data[GAIN_W-1:0];
          REG_HOLD_ALTITUDE: target_altitude = cfg_data;
          default: ;
        endcase
      end

      // Compare each accepted result with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: altitude %0d drive %0d",
                   $time, out_estimated_altitude, out_drive_output);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_estimated_altitude !== oldest.altitude) begin
            $display("%0t: estimated_altitude expected %0d, actual %0d",
                     $time, oldest.altitude, out_estimated_altitude);
            mismatch_count++;
          end
          if (out_drive_output !== oldest.drive) begin
            $display("%0t: drive_output expected %0d, actual %0d",
                     $time, oldest.drive, out_drive_output);
            mismatch_count++;
          end
        end
      end

      // Predict each accepted request
      if (in_valid && in_ready) begin
        predict_altitude_hold(in_raw_altitude, predicted);
        expected_results.push_back(predicted);
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

>>> tb/tb_baro_altitude_hold_pid_top.sv
`timescale 1ns / 1ps
// Testbench top for the altitude hold block: stimulus, back-pressure and verdict.
module tb_baro_altitude_hold_pid_top;
  import bahp_pkg::*;

  localparam int RANDOM_PHASES      = 8;
  localparam int REQUESTS_PER_PHASE = 172;
  localparam int HOLD_OFF_PHASE     = 5;
  localparam int HOLD_OFF_CYCLES    = 300;
  localparam int HOLD_OFF_BURST     = 60;
  localparam int STALL_LIMIT        = 4000;
  localparam int DRAIN_CYCLES       = 16;
  localparam int ALT_FIELD_MAX      = 1048575;
  localparam int ALT_FIELD_MIN      = -1048576;
  localparam int DIRECTED_ALTITUDES [14] = '{
    1000000, -1000000, 1048575, -1048576, 1000001, -1000001,
    0, 9, -9, 10, -10, 19, -19, 1
  };

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [ALT_W-1:0]     in_raw_altitude;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [ALT_W-1:0]     out_estimated_altitude;
  logic signed [DRIVE_W-1:0]   out_drive_output;

  int mismatch_count;
  int results_outstanding;
  int hold_off_asked = 0;
  int hold_off_served = 0;
  bit steady_sender;
  int walk_altitude;
  int hold_setting;

  baro_altitude_hold_pid_top uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_raw_altitude        (in_raw_altitude),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_estimated_altitude (out_estimated_altitude),
    .out_drive_output       (out_drive_output)
  );

  bahp_result_checker result_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_raw_altitude        (in_raw_altitude),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_estimated_altitude (out_estimated_altitude),
    .out_drive_output       (out_drive_output),
    .mismatch_count         (mismatch_count),
    .results_outstanding    (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when nothing moves on either channel for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Result side: random ready pattern, plus a long hold-off when asked
  initial begin
    int roll, ready_len, stall_len;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_asked != hold_off_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_served++;
      end else begin
        roll = $urandom_range(0, 99);
        ready_len = (roll < 20) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        if (roll < 20) stall_len = 0;
        else if (roll < 85) stall_len = $urandom_range(0, 3);
        else if (roll < 95) stall_len = $urandom_range(4, 12);
        else stall_len = $urandom_range(20, 60);
        out_ready <= 1'b1;
        repeat (ready_len) @(negedge clk);
        if (stall_len > 0) begin
          out_ready <= 1'b0;
          repeat (stall_len) @(negedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady_sender) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until accepted; returns at a falling edge
  task automatic send_request(input logic signed [ALT_W-1:0] raw);
    in_valid <= 1'b1;
    in_raw_altitude <= raw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      in_raw_altitude <= ALT_W'($urandom);
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every result has come out
  task automatic drain_block();
    in_valid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all four registers back to back; the block is idle here
  task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] d,
                               input logic signed [ALT_W-1:0] hold);
    cfg_we <= 1'b1;
    cfg_index <= REG_P_GAIN;
    cfg_data <= CFG_DATA_W'({$urandom, p});
    @(negedge clk);
    cfg_index <= REG_I_GAIN;
    cfg_data <= CFG_DATA_W'({$urandom, i});
    @(negedge clk);
    cfg_index <= REG_D_GAIN;
    cfg_data <= CFG_DATA_W'({$urandom, d});
    @(negedge clk);
    cfg_index <= REG_HOLD_ALTITUDE;
    cfg_data <= hold;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    hold_setting = int'(hold);
  endtask

  // Mostly altitude tracks around the target, with jumps, noise and extremes mixed in
  task automatic run_random_phase(input int count, input bit with_hold_off);
    int seq_left, mode, step, burst_left, beyond;
    logic signed [ALT_W-1:0] raw;
    seq_left = 0;
    burst_left = 0;
    mode = 0;
    step = 1;
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) steady_sender = ($urandom_range(0, 3) == 0);
      if (with_hold_off && k == count / 2) begin
        hold_off_asked++;
        burst_left = HOLD_OFF_BURST;
      end
      if (seq_left == 0) begin
        seq_left = $urandom_range(10, 60);
        mode = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
          0: step = 3;
          1: step = 25;
          default: step = 400;
        endcase
        if (mode < 60) walk_altitude = hold_setting + int'($urandom_range(0, 60)) - 30;
        else if (mode < 75) step = 20000;
      end
      seq_left--;

      if (mode < 75) begin
        walk_altitude += int'($urandom_range(0, 2 * step)) - step;
        if (walk_altitude > ALT_FIELD_MAX) walk_altitude = ALT_FIELD_MAX;
        if (walk_altitude < ALT_FIELD_MIN) walk_altitude = ALT_FIELD_MIN;
        raw = ALT_W'(walk_altitude);
      end else if (mode < 90) begin
        raw = ALT_W'($urandom);
      end else begin
        beyond = ALT_LIMIT + int'($urandom_range(1, ALT_FIELD_MAX - ALT_LIMIT));
        case ($urandom_range(0, 5))
          0: raw = ALT_POS;
          1: raw = ALT_NEG;
          2: raw = ALT_W'(ALT_FIELD_MAX);
          3: raw = ALT_W'(ALT_FIELD_MIN);
          4: raw = ALT_W'(beyond);
          default: raw = ALT_W'(-beyond);
        endcase
      end

      send_request(raw);
      if (burst_left > 0) burst_left--;
      else pause_sender(pick_gap());
    end
    drain_block();
  endtask

  initial begin
    logic [GAIN_W-1:0] p, i, d;
    logic signed [ALT_W-1:0] hold;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_P_GAIN;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_altitude = '0;
    steady_sender = 1'b0;
    walk_altitude = 0;
    hold_setting = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes and small errors at reset settings, then a slow ramp
    foreach (DIRECTED_ALTITUDES[k]) begin
      send_request(ALT_W'(DIRECTED_ALTITUDES[k]));
      pause_sender(pick_gap());
    end
    for (int k = 1; k <= 10; k++) begin
      send_request(ALT_W'(k * 15));
      pause_sender(pick_gap());
    end
    drain_block();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin p = 8'd255; i = 8'd255; d = 8'd255; hold = ALT_POS; end
        1: begin p = 8'd0; i = 8'd0; d = 8'd0; hold = ALT_NEG; end
        2: begin p = 8'd1; i = 8'd255; d = 8'd128; hold = ALT_W'(ALT_FIELD_MAX); end
        3: begin p = 8'd200; i = 8'd255; d = 8'd3; hold = ALT_W'(ALT_FIELD_MIN); end
        default: begin
          p = GAIN_W'($urandom_range(0, 255));
          i = GAIN_W'($urandom_range(0, 255));
          d = GAIN_W'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) hold = ALT_W'($urandom);
          else hold = ALT_W'(int'($urandom_range(0, 2 * ALT_LIMIT)) - ALT_LIMIT);
        end
      endcase
      load_settings(p, i, d, hold);
      run_random_phase(REQUESTS_PER_PHASE, phase == HOLD_OFF_PHASE);
    end

    while (results_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bahp_pkg.sv
rtl/bahp_cell.sv
rtl/bahp_cdiv.sv
rtl/bahp_window.sv
rtl/baro_altitude_hold_pid_top.sv
tb/bahp_result_checker.sv
tb/tb_baro_altitude_hold_pid_top.sv
